/* sv/awa_pkg.sv */
// -----------------------------------------------------------------------------
// Address window allocator package
// Shared types, codes and a helper function for the decode window allocator.
// -----------------------------------------------------------------------------
package awa_pkg;

  // Widest window index over the supported range of window counts.
  localparam int WIN_IDX_W = 5;

  // Window that is never handed out.
  localparam logic [WIN_IDX_W-1:0] RESERVED_WINDOW = 5'd13;

  // Masks and offsets used to build the register words.
  localparam logic [31:0] HIGH_HALF_MASK   = 32'hffff0000;
  localparam logic [7:0]  HIGH_BLOCK_START = 8'h90;

  // Request codes.
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Result status codes.
  typedef logic [2:0] status_t;
  localparam status_t ST_ADDED    = 3'd0;
  localparam status_t ST_OVERLAP  = 3'd1;
  localparam status_t ST_NOFREE   = 3'd2;
  localparam status_t ST_DELETED  = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_DONE
  } fsm_t;

  // One command beat.
  typedef struct packed {
    logic        op;
    logic [31:0] base_address;
    logic [31:0] window_size;
    logic        remap_requested;
    logic [31:0] remap_address;
    logic [3:0]  target_id;
    logic [7:0]  attribute;
  } cmd_t;

  // One response beat.
  typedef struct packed {
    status_t              status;
    logic [WIN_IDX_W-1:0] window_index;
    logic [7:0]           register_offset;
    logic                 write_valid;
    logic [31:0]          base_word;
    logic [31:0]          control_word;
    logic                 remap_written;
    logic [31:0]          remap_low_word;
  } rsp_t;

  // Requests from the controller to the window table.
  typedef struct packed {
    logic                 rd_en;
    logic [WIN_IDX_W-1:0] rd_addr;
    logic                 wr_en;
    logic                 clr_en;
    logic [WIN_IDX_W-1:0] wr_addr;
    logic [31:0]          wr_base;
    logic [31:0]          wr_size;
  } tbl_req_t;

  // Offset of a window's register block, modulo 256.
  function automatic logic [7:0] block_offset(input logic [WIN_IDX_W-1:0] w);
    logic [WIN_IDX_W-1:0] rel;
    rel = w - 5'd8;
    if (w < 5'd8) begin
      block_offset = {w[3:0], 4'b0000};
    end else begin
      block_offset = HIGH_BLOCK_START + 8'({rel, 3'b000});
    end
  endfunction

endpackage

/* sv/awa_if.sv */
// -----------------------------------------------------------------------------
// Address window allocator channels
// Valid/ready channels for command beats and response beats.
// -----------------------------------------------------------------------------
interface awa_cmd_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] base_address;
  logic [31:0] window_size;
  logic        remap_requested;
  logic [31:0] remap_address;
  logic [3:0]  target_id;
  logic [7:0]  attribute;

  modport source (
    output valid, op, base_address, window_size, remap_requested, remap_address,
           target_id, attribute,
    input  ready
  );
  modport sink (
    input  valid, op, base_address, window_size, remap_requested, remap_address,
           target_id, attribute,
    output ready
  );
endinterface

interface awa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [4:0]  window_index;
  logic [7:0]  register_offset;
  logic        write_valid;
  logic [31:0] base_word;
  logic [31:0] control_word;
  logic        remap_written;
  logic [31:0] remap_low_word;

  modport source (
    output valid, status, window_index, register_offset, write_valid, base_word,
           control_word, remap_written, remap_low_word,
    input  ready
  );
  modport sink (
    input  valid, status, window_index, register_offset, write_valid, base_word,
           control_word, remap_written, remap_low_word,
    output ready
  );
endinterface

/* sv/awa_table.sv */
// -----------------------------------------------------------------------------
// Window table
// Base/size memory with a registered read plus per-window enable bits.
// -----------------------------------------------------------------------------
module awa_table #(
  parameter int NUM_WINDOWS = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  awa_pkg::tbl_req_t      req,
  output logic [63:0]            rd_data,
  output logic [NUM_WINDOWS-1:0] enabled
);

  localparam int IDX_W = $clog2(NUM_WINDOWS);

  // Each word holds {base, size}; contents are only used for enabled windows.
  logic [63:0] mem [NUM_WINDOWS];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[IDX_W-1:0]] <= {req.wr_base, req.wr_size};
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[IDX_W-1:0]];
    end
  end

  // Enable bits: set when a window is added, cleared when it is deleted.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= '0;
    end else begin
      if (req.wr_en) begin
        enabled[req.wr_addr[IDX_W-1:0]] <= 1'b1;
      end
      if (req.clr_en) begin
        enabled[req.wr_addr[IDX_W-1:0]] <= 1'b0;
      end
    end
  end

endmodule

/* sv/awa_ctrl.sv */
// -----------------------------------------------------------------------------
// Allocator controller
// Scans the window table one entry per cycle, then commits and forms the result.
// -----------------------------------------------------------------------------
module awa_ctrl #(
  parameter int NUM_WINDOWS    = 20,
  parameter int NUM_REMAPPABLE = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  awa_pkg::cmd_t          cmd,
  input  logic                   res_free,
  output logic                   res_fire,
  output awa_pkg::rsp_t          res,
  output awa_pkg::tbl_req_t      tbl,
  input  logic [63:0]            rd_data,
  input  logic [NUM_WINDOWS-1:0] enabled
);

  localparam int IDX_W = $clog2(NUM_WINDOWS);
  localparam int CNT_W = $clog2(NUM_WINDOWS + 1);

  awa_pkg::fsm_t state, state_next;
  awa_pkg::cmd_t cur;
  logic [32:0]      hi;
  logic [CNT_W-1:0] cnt;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             free_hi_found;
  logic [IDX_W-1:0] free_hi_idx;
  logic             free_any_found;
  logic [IDX_W-1:0] free_any_idx;

  logic             accept;
  logic [IDX_W-1:0] cnt_idx;
  logic             slot_free;
  logic             slot_hi;
  logic [31:0]      ent_base;
  logic [31:0]      ent_size;
  logic [32:0]      ent_end;
  logic             ent_match;
  logic [awa_pkg::WIN_IDX_W-1:0] sel_idx;

  assign accept    = cmd_valid && cmd_ready;
  assign cmd_ready = (state == awa_pkg::S_IDLE);
  assign cnt_idx   = cnt[IDX_W-1:0];

  // Free slot test on the enable bits and the reserved window for the entry being scanned.
  assign slot_free = !enabled[cnt_idx] &&
                     (awa_pkg::WIN_IDX_W'(cnt_idx) != awa_pkg::RESERVED_WINDOW);
  assign slot_hi   = (cnt >= CNT_W'(NUM_REMAPPABLE));

  // Overlap or exact-match test on the entry read in the previous cycle.
  assign ent_base = rd_data[63:32];
  assign ent_size = rd_data[31:0];
  assign ent_end  = {1'b0, ent_base} + {1'b0, ent_size};

  always_comb begin
    if (cur.op == awa_pkg::OP_DELETE) begin
      ent_match = enabled[rd_idx] && (ent_base == cur.base_address) &&
                  (ent_size == cur.window_size);
    end else begin
      ent_match = enabled[rd_idx] && ({1'b0, cur.base_address} < ent_end) &&
                  (hi > {1'b0, ent_base});
    end
  end

  // State register and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= awa_pkg::S_IDLE;
      rd_vld         <= 1'b0;
      hit            <= 1'b0;
      free_hi_found  <= 1'b0;
      free_any_found <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= tbl.rd_en;
      if (accept) begin
        hit            <= 1'b0;
        free_hi_found  <= 1'b0;
        free_any_found <= 1'b0;
      end else begin
        if (state == awa_pkg::S_SCAN && slot_free) begin
          free_any_found <= 1'b1;
          if (slot_hi) begin
            free_hi_found <= 1'b1;
          end
        end
        if (rd_vld && ent_match) begin
          hit <= 1'b1;
        end
      end
    end
  end

  // Command capture, scan counter and first-found indexes.
  always_ff @(posedge clk) begin
    rd_idx <= cnt_idx;
    if (accept) begin
      cur <= cmd;
      hi  <= {1'b0, cmd.base_address} + {1'b0, cmd.window_size};
      cnt <= '0;
    end else begin
      if (state == awa_pkg::S_SCAN) begin
        cnt <= cnt + 1'b1;
        if (slot_free && !free_any_found) begin
          free_any_idx <= cnt_idx;
        end
        if (slot_free && slot_hi && !free_hi_found) begin
          free_hi_idx <= cnt_idx;
        end
      end
      if (rd_vld && ent_match && !hit) begin
        hit_idx <= rd_idx;
      end
    end
  end

  // Window picked for an add: a non-remappable one first unless a remap is asked.
  assign sel_idx = (!cur.remap_requested && free_hi_found) ?
                   awa_pkg::WIN_IDX_W'(free_hi_idx) : awa_pkg::WIN_IDX_W'(free_any_idx);

  // Next state, table requests and result. Table writes happen only in the
  // final state, so they never overlap the reads of the next scan.
  always_comb begin
    state_next  = state;
    tbl         = '0;
    tbl.rd_addr = awa_pkg::WIN_IDX_W'(cnt_idx);
    tbl.wr_base = cur.base_address;
    tbl.wr_size = cur.window_size;
    res         = '0;
    res_fire    = 1'b0;
    unique case (state)
      awa_pkg::S_IDLE: begin
        if (cmd_valid) begin
          state_next = awa_pkg::S_SCAN;
        end
      end
      awa_pkg::S_SCAN: begin
        tbl.rd_en = 1'b1;
        if (cnt == CNT_W'(NUM_WINDOWS - 1)) begin
          state_next = awa_pkg::S_TAIL;
        end
      end
      awa_pkg::S_TAIL: begin
        state_next = awa_pkg::S_DONE;
      end
      awa_pkg::S_DONE: begin
        if (cur.op == awa_pkg::OP_DELETE) begin
          if (hit) begin
            res.status          = awa_pkg::ST_DELETED;
            res.window_index    = awa_pkg::WIN_IDX_W'(hit_idx);
            res.register_offset = awa_pkg::block_offset(awa_pkg::WIN_IDX_W'(hit_idx));
            res.write_valid     = 1'b1;
            res.remap_written   = (awa_pkg::WIN_IDX_W'(hit_idx) <
                                   awa_pkg::WIN_IDX_W'(NUM_REMAPPABLE));
          end else begin
            res.status = awa_pkg::ST_NOTFOUND;
          end
        end else if (hit) begin
          res.status = awa_pkg::ST_OVERLAP;
        end else if (!free_any_found) begin
          res.status = awa_pkg::ST_NOFREE;
        end else begin
          res.status          = awa_pkg::ST_ADDED;
          res.window_index    = sel_idx;
          res.register_offset = awa_pkg::block_offset(sel_idx);
          res.write_valid     = 1'b1;
          res.base_word       = cur.base_address & awa_pkg::HIGH_HALF_MASK;
          res.control_word    = ((cur.window_size - 32'd1) & awa_pkg::HIGH_HALF_MASK) |
                                {16'h0000, cur.attribute, cur.target_id, 4'h1};
          if (sel_idx < awa_pkg::WIN_IDX_W'(NUM_REMAPPABLE)) begin
            res.remap_written  = 1'b1;
            res.remap_low_word = (cur.remap_requested ? cur.remap_address :
                                  cur.base_address) & awa_pkg::HIGH_HALF_MASK;
          end
        end
        if (res_free) begin
          res_fire   = 1'b1;
          state_next = awa_pkg::S_IDLE;
          tbl.wr_addr = (cur.op == awa_pkg::OP_DELETE) ?
                        awa_pkg::WIN_IDX_W'(hit_idx) : sel_idx;
          tbl.clr_en  = (cur.op == awa_pkg::OP_DELETE) && hit;
          tbl.wr_en   = (res.status == awa_pkg::ST_ADDED);
        end
      end
      default: begin
        state_next = awa_pkg::S_IDLE;
      end
    endcase
  end

  // Read data is only evaluated in the cycle after a scan read.
  a_rd_after_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state) == awa_pkg::S_SCAN)
    else $error("table read data consumed without a scan read");

  // A free non-remappable slot is also a free slot.
  a_free_order: assert property (@(posedge clk) disable iff (rst)
    free_hi_found |-> free_any_found)
    else $error("free slot flags out of order");

  // An added window was disabled and is not the reserved one.
  a_add_free: assert property (@(posedge clk) disable iff (rst)
    (res_fire && res.status == awa_pkg::ST_ADDED) |->
      (!enabled[sel_idx[IDX_W-1:0]] && sel_idx != awa_pkg::RESERVED_WINDOW))
    else $error("add picked a window that is in use or reserved");

  // A deleted window was enabled and is cleared on the next cycle.
  a_del_clear: assert property (@(posedge clk) disable iff (rst)
    (res_fire && res.status == awa_pkg::ST_DELETED) |=>
      !enabled[$past(hit_idx)])
    else $error("deleted window still enabled");

endmodule

/* sv/address_window_allocator.sv */
// -----------------------------------------------------------------------------
// Address window allocator
// Allocates and frees bus address-decode windows and returns register words.
// -----------------------------------------------------------------------------
//
//  Channel  Role    Beat contents
//  -------  ------  -------------------------------------------------------
//  cmd      sink    op, base, size, remap request/address, target, attribute
//  rsp      source  status, window index, register offset and register words
//
//  Each command runs through accept, one table memory read per window, a step for
//  the last read's data and a commit step.
//  Reset clears the enable bits and the controller; base/size need no clearing.
//  A response waits in the output register while the next command is taken;
//  the controller holds in its commit state while that register is still full.
//
module address_window_allocator #(
  parameter int NUM_WINDOWS    = 20,
  parameter int NUM_REMAPPABLE = 8
) (
  input logic      clk,
  input logic      rst,
  awa_cmd_if.sink   cmd,
  awa_rsp_if.source rsp
);

  awa_pkg::cmd_t     cmd_beat;
  awa_pkg::rsp_t     res;
  awa_pkg::rsp_t     rsp_reg;
  awa_pkg::tbl_req_t tbl;
  logic              res_fire;
  logic              res_free;
  logic [63:0]       rd_data;
  logic [NUM_WINDOWS-1:0] enabled;

  // Gather the command beat.
  assign cmd_beat.op              = cmd.op;
  assign cmd_beat.base_address    = cmd.base_address;
  assign cmd_beat.window_size     = cmd.window_size;
  assign cmd_beat.remap_requested = cmd.remap_requested;
  assign cmd_beat.remap_address   = cmd.remap_address;
  assign cmd_beat.target_id       = cmd.target_id;
  assign cmd_beat.attribute       = cmd.attribute;

  awa_ctrl #(
    .NUM_WINDOWS    (NUM_WINDOWS),
    .NUM_REMAPPABLE (NUM_REMAPPABLE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd       (cmd_beat),
    .res_free  (res_free),
    .res_fire  (res_fire),
    .res       (res),
    .tbl       (tbl),
    .rd_data   (rd_data),
    .enabled   (enabled)
  );

  awa_table #(
    .NUM_WINDOWS (NUM_WINDOWS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (tbl),
    .rd_data (rd_data),
    .enabled (enabled)
  );

  // Output register for the response beat.
  assign res_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      rsp_reg <= res;
    end
  end

  assign rsp.status          = rsp_reg.status;
  assign rsp.window_index    = rsp_reg.window_index;
  assign rsp.register_offset = rsp_reg.register_offset;
  assign rsp.write_valid     = rsp_reg.write_valid;
  assign rsp.base_word       = rsp_reg.base_word;
  assign rsp.control_word    = rsp_reg.control_word;
  assign rsp.remap_written   = rsp_reg.remap_written;
  assign rsp.remap_low_word  = rsp_reg.remap_low_word;

endmodule

/* verif/address_window_allocator_test.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Address window allocator testbench
// Sends add and delete requests over the command channel. Each accepted beat
// is run through a local copy of the window table to work out its response,
// and each response beat is compared field by field with the oldest one
// still pending. Both channels stall at random in two of the three phases.
// -----------------------------------------------------------------------------
module address_window_allocator_test;

  localparam int NUM_WIN     = 20;
  localparam int NUM_REMAP   = 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_PRINTED = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  awa_cmd_if cmd_ch ();
  awa_rsp_if rsp_ch ();

  address_window_allocator #(
    .NUM_WINDOWS    (NUM_WIN),
    .NUM_REMAPPABLE (NUM_REMAP)
  ) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // Local copy of the window table.
  logic        win_enabled [NUM_WIN];
  logic [31:0] win_base    [NUM_WIN];
  logic [31:0] win_size    [NUM_WIN];

  awa_pkg::rsp_t    expected_rsps[$];
  awa_pkg::status_t last_status;
  int               mismatch_count = 0;
  int               cycle_count    = 0;
  int               cmd_idle_pct   = 0;
  int               rsp_idle_pct   = 0;

  // Free-running clock, 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Register block offset of a window, modulo 256.
  function automatic logic [7:0] window_offset(input int w);
    if (w < 8) begin
      return 8'(w * 16);
    end
    return 8'(int'(awa_pkg::HIGH_BLOCK_START) + (w - 8) * 8);
  endfunction

  // Applies one request to the local table and returns the response it causes.
  function automatic awa_pkg::rsp_t predict_window_request(input awa_pkg::cmd_t c);
    awa_pkg::rsp_t r;
    int            found;
    logic          clash;
    logic [32:0]   lo, hi, eb, ee;
    r = '0;
    found = -1;
    if (c.op == awa_pkg::OP_DELETE) begin
      for (int w = 0; w < NUM_WIN; w++) begin
        if (found < 0 && win_enabled[w] && win_base[w] == c.base_address &&
            win_size[w] == c.window_size) begin
          found = w;
        end
      end
      if (found < 0) begin
        r.status = awa_pkg::ST_NOTFOUND;
      end else begin
        win_enabled[found] = 1'b0;
        r.status          = awa_pkg::ST_DELETED;
        r.window_index    = found[4:0];
        r.register_offset = window_offset(found);
        r.write_valid     = 1'b1;
        r.remap_written   = (found < NUM_REMAP);
      end
      return r;
    end

    // Overlap test with 33-bit end addresses, so nothing wraps.
    clash = 1'b0;
    lo = {1'b0, c.base_address};
    hi = {1'b0, c.base_address} + {1'b0, c.window_size};
    for (int w = 0; w < NUM_WIN; w++) begin
      eb = {1'b0, win_base[w]};
      ee = eb + {1'b0, win_size[w]};
      if (win_enabled[w] && lo < ee && hi > eb) begin
        clash = 1'b1;
      end
    end
    if (clash) begin
      r.status = awa_pkg::ST_OVERLAP;
      return r;
    end

    // Plain windows are preferred unless a remap is wanted.
    if (!c.remap_requested) begin
      for (int w = NUM_REMAP; w < NUM_WIN; w++) begin
        if (found < 0 && w != int'(awa_pkg::RESERVED_WINDOW) && !win_enabled[w]) begin
          found = w;
        end
      end
    end
    for (int w = 0; w < NUM_WIN; w++) begin
      if (found < 0 && w != int'(awa_pkg::RESERVED_WINDOW) && !win_enabled[w]) begin
        found = w;
      end
    end
    if (found < 0) begin
      r.status = awa_pkg::ST_NOFREE;
      return r;
    end

    win_enabled[found] = 1'b1;
    win_base[found]    = c.base_address;
    win_size[found]    = c.window_size;
    r.status          = awa_pkg::ST_ADDED;
    r.window_index    = found[4:0];
    r.register_offset = window_offset(found);
    r.write_valid     = 1'b1;
    r.base_word       = c.base_address & awa_pkg::HIGH_HALF_MASK;
    r.control_word    = ((c.window_size - 32'd1) & awa_pkg::HIGH_HALF_MASK) |
                        {16'h0000, c.attribute, c.target_id, 4'b0001};
    if (found < NUM_REMAP) begin
      r.remap_written  = 1'b1;
      r.remap_low_word = (c.remap_requested ? c.remap_address : c.base_address) &
                         awa_pkg::HIGH_HALF_MASK;
    end
    return r;
  endfunction

  function automatic awa_pkg::cmd_t make_cmd(input logic op, input logic [31:0] base,
                                             input logic [31:0] size,
                                             input logic remap_req,
                                             input logic [31:0] remap_addr,
                                             input logic [3:0] target,
                                             input logic [7:0] attr);
    awa_pkg::cmd_t c;
    c.op              = op;
    c.base_address    = base;
    c.window_size     = size;
    c.remap_requested = remap_req;
    c.remap_address   = remap_addr;
    c.target_id       = target;
    c.attribute       = attr;
    return c;
  endfunction

  // Add of a random, mostly small range anywhere in the address space.
  function automatic awa_pkg::cmd_t fresh_add_cmd();
    logic [31:0] size_mask;
    size_mask = (32'd1 << $urandom_range(24, 0)) - 32'd1;
    return make_cmd(awa_pkg::OP_ADD, $urandom, $urandom & size_mask,
                    1'($urandom_range(1, 0)), $urandom, 4'($urandom_range(15, 0)),
                    8'($urandom_range(255, 0)));
  endfunction

  // Random enabled window, or -1 when the table is empty.
  function automatic int random_enabled_window();
    int live[$];
    for (int w = 0; w < NUM_WIN; w++) begin
      if (win_enabled[w]) begin
        live.push_back(w);
      end
    end
    if (live.size() == 0) begin
      return -1;
    end
    return live[$urandom_range(live.size() - 1, 0)];
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%08h, expected 0x%08h", name, got, want));
    end
  endtask

  // Drives one command beat, then predicts its response once it is accepted.
  task automatic send_request(input awa_pkg::cmd_t c);
    awa_pkg::rsp_t r;
    while ($urandom_range(99, 0) < cmd_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid           <= 1'b1;
    cmd_ch.op              <= c.op;
    cmd_ch.base_address    <= c.base_address;
    cmd_ch.window_size     <= c.window_size;
    cmd_ch.remap_requested <= c.remap_requested;
    cmd_ch.remap_address   <= c.remap_address;
    cmd_ch.target_id       <= c.target_id;
    cmd_ch.attribute       <= c.attribute;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    r = predict_window_request(c);
    expected_rsps.push_back(r);
    last_status = r.status;
  endtask

  // Holds the command channel idle until every pending response has come.
  task automatic wait_for_drain();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_rsps.size() != 0);
  endtask

  // Response side: compare each beat with the oldest prediction.
  task automatic check_response();
    awa_pkg::rsp_t want;
    if (expected_rsps.size() == 0) begin
      report_mismatch($sformatf("response beat with nothing pending, status %0d",
                                rsp_ch.status));
      return;
    end
    want = expected_rsps.pop_front();
    check_field("status", 32'(rsp_ch.status), 32'(want.status));
    check_field("window_index", 32'(rsp_ch.window_index), 32'(want.window_index));
    check_field("register_offset", 32'(rsp_ch.register_offset),
                32'(want.register_offset));
    check_field("write_valid", 32'(rsp_ch.write_valid), 32'(want.write_valid));
    check_field("base_word", rsp_ch.base_word, want.base_word);
    check_field("control_word", rsp_ch.control_word, want.control_word);
    check_field("remap_written", 32'(rsp_ch.remap_written), 32'(want.remap_written));
    check_field("remap_low_word", rsp_ch.remap_low_word, want.remap_low_word);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      check_response();
    end
    rsp_ch.ready <= ($urandom_range(99, 0) >= rsp_idle_pct);
  end

  // Extremes, wraparound of the end address, zero size, touching ranges and
  // exact-match rules for delete.
  task automatic test_directed_edges();
    send_request(make_cmd(awa_pkg::OP_ADD, 32'h0, 32'hffffffff, 1'b0, 32'h0, 4'hf,
                          8'hff));
    send_request(make_cmd(awa_pkg::OP_ADD, 32'hffff0000, 32'h10000, 1'b0, 32'h0, 4'h1,
                          8'h01));
    send_request(make_cmd(awa_pkg::OP_DELETE, 32'h0, 32'hffffffff, 1'b0, 32'h0, 4'h0,
                          8'h00));
    send_request(make_cmd(awa_pkg::OP_DELETE, 32'h0, 32'hffffffff, 1'b1, 32'hffffffff,
                          4'hf, 8'hff));
    send_request(make_cmd(awa_pkg::OP_ADD, 32'hffffffff, 32'hffffffff, 1'b1,
                          32'hffffffff, 4'h0, 8'h00));
    send_request(make_cmd(awa_pkg::OP_ADD, 32'hfffffffe, 32'h1, 1'b0, 32'h0, 4'ha,
                          8'h5a));
    send_request(make_cmd(awa_pkg::OP_ADD, 32'h1000, 32'h0, 1'b1, 32'h12345678, 4'h5,
                          8'ha5));
    send_request(make_cmd(awa_pkg::OP_ADD, 32'h1000, 32'h0, 1'b1, 32'h0, 4'h3, 8'h3c));
    send_request(make_cmd(awa_pkg::OP_ADD, 32'h800, 32'h1000, 1'b0, 32'h0, 4'h6,
                          8'h66));
    send_request(make_cmd(awa_pkg::OP_DELETE, 32'h1000, 32'h0, 1'b0, 32'h0, 4'h0,
                          8'h00));
    send_request(make_cmd(awa_pkg::OP_DELETE, 32'hfffffffe, 32'h1, 1'b0, 32'h0, 4'h0,
                          8'h00));
    send_request(make_cmd(awa_pkg::OP_DELETE, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0,
                          4'h0, 8'h00));
    send_request(make_cmd(awa_pkg::OP_DELETE, 32'h1000, 32'h0, 1'b0, 32'h0, 4'h0,
                          8'h00));
    send_request(make_cmd(awa_pkg::OP_ADD, 32'h20000, 32'h10000, 1'b0, 32'h0, 4'h9,
                          8'h99));
    send_request(make_cmd(awa_pkg::OP_ADD, 32'h30000, 32'h10000, 1'b0, 32'h0, 4'hc,
                          8'hc3));
    send_request(make_cmd(awa_pkg::OP_ADD, 32'h10000, 32'h10000, 1'b0, 32'h0, 4'h7,
                          8'h7e));
    send_request(make_cmd(awa_pkg::OP_DELETE, 32'h20000, 32'h10001, 1'b0, 32'h0, 4'h0,
                          8'h00));
    send_request(make_cmd(awa_pkg::OP_DELETE, 32'h20000, 32'h10000, 1'b0, 32'h0, 4'h0,
                          8'h00));
    send_request(make_cmd(awa_pkg::OP_DELETE, 32'h30000, 32'h10000, 1'b0, 32'h0, 4'h0,
                          8'h00));
    send_request(make_cmd(awa_pkg::OP_DELETE, 32'h10000, 32'h10000, 1'b0, 32'h0, 4'h0,
                          8'h00));
  endtask

  // Fills the table until an add finds no free window, then frees every
  // window in random order.
  task automatic test_table_exhaustion();
    int            guard;
    int            w;
    awa_pkg::cmd_t c;
    guard = 0;
    do begin
      send_request(fresh_add_cmd());
      guard++;
    end while (last_status != awa_pkg::ST_NOFREE && guard < 200);
    send_request(fresh_add_cmd());
    w = random_enabled_window();
    while (w >= 0) begin
      c = fresh_add_cmd();
      c.op = awa_pkg::OP_DELETE;
      c.base_address = win_base[w];
      c.window_size  = win_size[w];
      send_request(c);
      w = random_enabled_window();
    end
    c = fresh_add_cmd();
    c.op = awa_pkg::OP_DELETE;
    send_request(c);
  endtask

  // Mix of fresh adds, adds that land inside a live window, deletes of live
  // windows, near-miss deletes and fully random requests.
  task automatic test_mixed_traffic(input int count);
    int            pick;
    int            w;
    logic [31:0]   offs;
    awa_pkg::cmd_t c;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99, 0);
      w = random_enabled_window();
      c = fresh_add_cmd();
      if (pick < 45) begin
        // Fresh add as generated.
      end else if (pick < 60 && w >= 0) begin
        offs = (win_size[w] == 0) ? 32'h0 : $urandom_range(win_size[w] - 1, 0);
        c.base_address = win_base[w] + offs;
        c.window_size  = 32'd1 + $urandom_range(32'hffff, 0);
      end else if (pick < 85 && w >= 0) begin
        c.op = awa_pkg::OP_DELETE;
        c.base_address = win_base[w];
        c.window_size  = win_size[w];
      end else if (pick < 95) begin
        c.op = awa_pkg::OP_DELETE;
        if (w >= 0 && $urandom_range(1, 0) == 1) begin
          c.base_address = win_base[w];
          c.window_size  = win_size[w] + 32'd1;
        end
      end else begin
        c.op = 1'($urandom_range(1, 0));
        c.window_size = $urandom;
      end
      send_request(c);
    end
  endtask

  initial begin
    for (int w = 0; w < NUM_WIN; w++) begin
      win_enabled[w] = 1'b0;
      win_base[w]    = '0;
      win_size[w]    = '0;
    end
    cmd_ch.valid           <= 1'b0;
    cmd_ch.op              <= awa_pkg::OP_ADD;
    cmd_ch.base_address    <= '0;
    cmd_ch.window_size     <= '0;
    cmd_ch.remap_requested <= 1'b0;
    cmd_ch.remap_address   <= '0;
    cmd_ch.target_id       <= '0;
    cmd_ch.attribute       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Sender stalls lightly, receiver heavily.
    cmd_idle_pct = 28;
    rsp_idle_pct = 49;
    test_directed_edges();
    test_table_exhaustion();
    test_mixed_traffic(510);
    wait_for_drain();

    // Roles swapped.
    cmd_idle_pct = 49;
    rsp_idle_pct = 28;
    test_table_exhaustion();
    test_mixed_traffic(510);
    wait_for_drain();

    // Back to back on both sides.
    cmd_idle_pct = 0;
    rsp_idle_pct = 0;
    test_table_exhaustion();
    test_mixed_traffic(510);
    wait_for_drain();

    // Leave room for any stray response beat.
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
